FILE: src/plpf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plpf_pkg
// Shared types, constants and the exp2 coefficient table of the power-law
// pair force pipeline.
// ----------------------------------------------------------------------------
package plpf_pkg;

	localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
	localparam logic [31:0] SAT32   = 32'hFFFF_FFFF;

	localparam logic [31:0] RST_WELL_DEPTH    = 32'h0001_0000;
	localparam logic [31:0] RST_CONTACT_DIST  = 32'h0001_0000;
	localparam logic [31:0] RST_POWER_EXP     = 32'h0002_0000;
	localparam logic [31:0] RST_CUTOFF_SQ     = 32'h0001_0000;
	localparam logic        RST_ENERGY_ENABLE = 1'b1;

	typedef enum logic [2:0] {
		REG_WELL_DEPTH       = 3'd0,
		REG_CONTACT_DISTANCE = 3'd1,
		REG_POWER_EXPONENT   = 3'd2,
		REG_CUTOFF_SQUARED   = 3'd3,
		REG_ENERGY_ENABLE    = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [2:0][31:0] mag;
		logic [2:0]       neg;
		logic             in_cut;
	} pair_t;

	typedef struct packed {
		pair_t       pair;
		logic [31:0] r;
		logic        base_ok;
	} geo_t;

	typedef struct packed {
		geo_t geo;
		logic sat;
	} fdiv_t;

	typedef struct packed {
		pair_t       pair;
		logic        live;
		logic        r_nz;
		logic [31:0] energy;
		logic        sat;
	} sdiv_t;

	// c_i = 2^(-2^-i) in Q1.30, by repeated floor square root from 0.5
	typedef logic [16:1][29:0] exp_tab_t;

	function automatic exp_tab_t exp_table();
		exp_tab_t    tab;
		logic [63:0] c;
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] bt;
		tab = '0;
		c = 64'd1 << 29;
		for (int i = 1; i <= 16; i++) begin
			v = c << 30;
			res = '0;
			bt = 64'd1 << 62;
			while (bt > v) bt = bt >> 2;
			while (bt != 0) begin
				if (v >= res + bt) begin
					v = v - (res + bt);
					res = (res >> 1) + bt;
				end else begin
					res = res >> 1;
				end
				bt = bt >> 2;
			end
			c = res;
			tab[i] = c[29:0];
		end
		return tab;
	endfunction

endpackage

FILE: src/plpf_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plpf_sqrt
// Pipelined floor square root of a 64-bit radicand, one root bit per stage.
// ----------------------------------------------------------------------------
module plpf_sqrt #(
	parameter int SBW = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_v,
	input  logic [63:0]    in_rad,
	input  logic [SBW-1:0] in_sb,
	output logic           out_v,
	output logic [31:0]    out_root,
	output logic [SBW-1:0] out_sb
);

	localparam int STEPS = 32;

	logic           v_s    [STEPS];
	logic [63:0]    rad_s  [STEPS];
	logic [32:0]    rem_s  [STEPS];
	logic [31:0]    root_s [STEPS];
	logic [SBW-1:0] sb_s   [STEPS];

	for (genvar g = 0; g < STEPS; g++) begin : g_step
		logic           pv;
		logic [63:0]    prad;
		logic [32:0]    prem;
		logic [31:0]    proot;
		logic [SBW-1:0] psb;
		logic [34:0]    shl;
		logic [34:0]    trial;
		logic           fits;

		if (g == 0) begin : g_first
			assign pv    = in_v;
			assign prad  = in_rad;
			assign prem  = '0;
			assign proot = '0;
			assign psb   = in_sb;
		end else begin : g_next
			assign pv    = v_s[g-1];
			assign prad  = rad_s[g-1];
			assign prem  = rem_s[g-1];
			assign proot = root_s[g-1];
			assign psb   = sb_s[g-1];
		end

		assign shl   = {prem, prad[63:62]};
		assign trial = {1'b0, proot, 2'b01};
		assign fits  = shl >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g] <= 1'b0;
			end else if (en) begin
				v_s[g] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[g]  <= {prad[61:0], 2'b00};
				rem_s[g]  <= fits ? 33'(shl - trial) : shl[32:0];
				root_s[g] <= {proot[30:0], fits};
				sb_s[g]   <= psb;
			end
		end
	end

	assign out_v    = v_s[STEPS-1];
	assign out_root = root_s[STEPS-1];
	assign out_sb   = sb_s[STEPS-1];

endmodule

FILE: src/plpf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plpf_div
// Pipelined restoring divider, one quotient bit per stage. The starting
// remainder must be below the divisor; the divisor travels with each item.
// ----------------------------------------------------------------------------
module plpf_div #(
	parameter int NB  = 32,
	parameter int SBW = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_v,
	input  logic [31:0]    in_rem,
	input  logic [NB-1:0]  in_low,
	input  logic [31:0]    divisor,
	input  logic [SBW-1:0] in_sb,
	output logic           out_v,
	output logic [NB-1:0]  out_quot,
	output logic [SBW-1:0] out_sb
);

	logic           v_s    [NB];
	logic [31:0]    rem_s  [NB];
	logic [NB-1:0]  low_s  [NB];
	logic [NB-1:0]  quot_s [NB];
	logic [31:0]    dv_s   [NB];
	logic [SBW-1:0] sb_s   [NB];

	for (genvar g = 0; g < NB; g++) begin : g_step
		logic           pv;
		logic [31:0]    prem;
		logic [NB-1:0]  plow;
		logic [NB-1:0]  pquot;
		logic [31:0]    pdiv;
		logic [SBW-1:0] psb;
		logic [32:0]    shl;
		logic           fits;

		if (g == 0) begin : g_first
			assign pv    = in_v;
			assign prem  = in_rem;
			assign plow  = in_low;
			assign pquot = '0;
			assign pdiv  = divisor;
			assign psb   = in_sb;
		end else begin : g_next
			assign pv    = v_s[g-1];
			assign prem  = rem_s[g-1];
			assign plow  = low_s[g-1];
			assign pquot = quot_s[g-1];
			assign pdiv  = dv_s[g-1];
			assign psb   = sb_s[g-1];
		end

		assign shl  = {prem, plow[NB-1]};
		assign fits = shl >= {1'b0, pdiv};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g] <= 1'b0;
			end else if (en) begin
				v_s[g] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g]  <= fits ? 32'(shl - {1'b0, pdiv}) : shl[31:0];
				low_s[g]  <= {plow[NB-2:0], 1'b0};
				quot_s[g] <= {pquot[NB-2:0], fits};
				dv_s[g]   <= pdiv;
				sb_s[g]   <= psb;
			end
		end
	end

	assign out_v    = v_s[NB-1];
	assign out_quot = quot_s[NB-1];
	assign out_sb   = sb_s[NB-1];

endmodule

FILE: src/plpf_log2.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plpf_log2
// Pipelined -log2 of a Q1.16 base in (0,1]: normalize, then one squaring
// per stage for each of 16 fraction bits, then a final combining stage.
// ----------------------------------------------------------------------------
module plpf_log2 #(
	parameter int SBW = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_v,
	input  logic [16:0]    in_base,
	input  logic [SBW-1:0] in_sb,
	output logic           out_v,
	output logic [20:0]    out_nlog,
	output logic [SBW-1:0] out_sb
);

	localparam int STEPS = 16;

	logic [4:0]     msb;
	logic [30:0]    norm;

	logic           nv_s1;
	logic [30:0]    ny_s1;
	logic [4:0]     np_s1;
	logic [SBW-1:0] nsb_s1;

	logic           v_s  [STEPS];
	logic [30:0]    y_s  [STEPS];
	logic [15:0]    fr_s [STEPS];
	logic [4:0]     p_s  [STEPS];
	logic [SBW-1:0] sb_s [STEPS];

	logic           v_sl;
	logic [20:0]    nl_sl;
	logic [SBW-1:0] sb_sl;

	always_comb begin
		msb = '0;
		for (int i = 0; i <= 16; i++) begin
			if (in_base[i]) msb = 5'(i);
		end
		norm = {14'b0, in_base} << (5'd30 - msb);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nv_s1 <= 1'b0;
		end else if (en) begin
			nv_s1 <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ny_s1  <= norm;
			np_s1  <= msb;
			nsb_s1 <= in_sb;
		end
	end

	for (genvar g = 0; g < STEPS; g++) begin : g_step
		logic           pv;
		logic [30:0]    py;
		logic [15:0]    pfr;
		logic [4:0]     pp;
		logic [SBW-1:0] psb;
		logic [61:0]    sq;
		logic           over;

		if (g == 0) begin : g_first
			assign pv  = nv_s1;
			assign py  = ny_s1;
			assign pfr = '0;
			assign pp  = np_s1;
			assign psb = nsb_s1;
		end else begin : g_next
			assign pv  = v_s[g-1];
			assign py  = y_s[g-1];
			assign pfr = fr_s[g-1];
			assign pp  = p_s[g-1];
			assign psb = sb_s[g-1];
		end

		assign sq   = py * py;
		assign over = sq[61];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g] <= 1'b0;
			end else if (en) begin
				v_s[g] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				y_s[g]  <= over ? sq[61:31] : sq[60:30];
				fr_s[g] <= {pfr[14:0], over};
				p_s[g]  <= pp;
				sb_s[g] <= psb;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sl <= 1'b0;
		end else if (en) begin
			v_sl <= v_s[STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nl_sl <= {5'd16 - p_s[STEPS-1], 16'h0} - {5'b0, fr_s[STEPS-1]};
			sb_sl <= sb_s[STEPS-1];
		end
	end

	assign out_v    = v_sl;
	assign out_nlog = nl_sl;
	assign out_sb   = sb_sl;

endmodule

FILE: src/plpf_pow.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plpf_pow
// Pipelined b^e from -log2(b): scale by the exponent, then one coefficient
// multiply per fraction bit, then the integer shift.
// ----------------------------------------------------------------------------
module plpf_pow
	import plpf_pkg::*;
#(
	parameter int SBW = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_v,
	input  logic [20:0]    in_nlog,
	input  logic [31:0]    expo,
	input  logic [SBW-1:0] in_sb,
	output logic           out_v,
	output logic [31:0]    out_pow,
	output logic [SBW-1:0] out_sb
);

	localparam int       STEPS = 16;
	localparam exp_tab_t EXP_C = exp_table();

	logic [52:0]    tprod;

	logic           v_s1;
	logic [36:0]    t_s1;
	logic [SBW-1:0] sb_s1;

	logic           v_s   [STEPS];
	logic [30:0]    acc_s [STEPS];
	logic [36:0]    t_s   [STEPS];
	logic [SBW-1:0] sb_s  [STEPS];

	logic [20:0]    k;
	logic [4:0]     shamt;

	logic           v_sl;
	logic [31:0]    pw_sl;
	logic [SBW-1:0] sb_sl;

	assign tprod = expo * in_nlog;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s1  <= tprod[52:16];
			sb_s1 <= in_sb;
		end
	end

	for (genvar g = 0; g < STEPS; g++) begin : g_step
		logic           pv;
		logic [30:0]    pacc;
		logic [36:0]    pt;
		logic [SBW-1:0] psb;
		logic [60:0]    prod;

		if (g == 0) begin : g_first
			assign pv   = v_s1;
			assign pacc = 31'h4000_0000;
			assign pt   = t_s1;
			assign psb  = sb_s1;
		end else begin : g_next
			assign pv   = v_s[g-1];
			assign pacc = acc_s[g-1];
			assign pt   = t_s[g-1];
			assign psb  = sb_s[g-1];
		end

		assign prod = pacc * EXP_C[g+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g] <= 1'b0;
			end else if (en) begin
				v_s[g] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				acc_s[g] <= pt[15-g] ? prod[60:30] : pacc;
				t_s[g]   <= pt;
				sb_s[g]  <= psb;
			end
		end
	end

	assign k     = t_s[STEPS-1][36:16];
	assign shamt = 5'd14 + k[4:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sl <= 1'b0;
		end else if (en) begin
			v_sl <= v_s[STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pw_sl <= (k > 21'd16) ? '0 : ({1'b0, acc_s[STEPS-1]} >> shamt);
			sb_sl <= sb_s[STEPS-1];
		end
	end

	assign out_v   = v_sl;
	assign out_pow = pw_sl;
	assign out_sb  = sb_sl;

endmodule

FILE: src/power_law_pair_force.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// power_law_pair_force
// Soft-sphere power-law pair force: one pair displacement in, force
// components, force scale, energy and cutoff flag out.
//
//   channel  dir  payload
//   s_*      in   tdata: sep_x, sep_y, sep_z
//   m_*      out  tdata: push_x, push_y, push_z, force_scale, pair_energy;
//                 tuser: within_cutoff
//   cfg_*    in   index / data register write
//
// One transaction per cycle when not stalled. The pipeline is the 32-step square
// root, the 16-step ratio divider, the 18-stage log2 and exp2 units and the
// two 32-step dividers in series (force, then scale), plus 12 single stages.
// Reset clears every valid bit and loads the register reset values.
// A stall on m_tready freezes the whole pipeline and drops s_tready.
// ----------------------------------------------------------------------------
module power_law_pair_force
	import plpf_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [95:0]  s_tdata,   // sep_x, sep_y, sep_z
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [159:0] m_tdata,   // push_x, push_y, push_z, force_scale, pair_energy
	output logic         m_tuser,   // within_cutoff
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	localparam int PAIR_W = $bits(pair_t);
	localparam int GEO_W  = $bits(geo_t);
	localparam int FDIV_W = $bits(fdiv_t);
	localparam int SDIV_W = $bits(sdiv_t);

	logic [31:0] eps_q;
	logic [31:0] sigma_q;
	logic [31:0] alpha_q;
	logic [31:0] alpha_m1_q;
	logic [31:0] cutoff_q;
	logic        energy_en_q;
	logic [31:0] alpha_w;

	logic adv;

	// config
	assign alpha_w = (cfg_data < ONE_Q16) ? ONE_Q16 : cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q       <= RST_WELL_DEPTH;
			sigma_q     <= RST_CONTACT_DIST;
			alpha_q     <= RST_POWER_EXP;
			alpha_m1_q  <= RST_POWER_EXP - ONE_Q16;
			cutoff_q    <= RST_CUTOFF_SQ;
			energy_en_q <= RST_ENERGY_ENABLE;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_WELL_DEPTH:       eps_q <= cfg_data;
				REG_CONTACT_DISTANCE: sigma_q <= (cfg_data == '0) ? 32'd1 : cfg_data;
				REG_POWER_EXPONENT: begin
					alpha_q    <= alpha_w;
					alpha_m1_q <= alpha_w - ONE_Q16;
				end
				REG_CUTOFF_SQUARED:   cutoff_q <= cfg_data;
				REG_ENERGY_ENABLE:    energy_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// stage 1: magnitudes
	logic             v_s1;
	pair_t            pair_s1;
	pair_t            pair_in;

	always_comb begin
		pair_in = '0;
		for (int i = 0; i < 3; i++) begin
			pair_in.neg[i] = s_tdata[32*i+31];
			pair_in.mag[i] = s_tdata[32*i+31] ? 32'(-s_tdata[32*i +: 32])
			                                  : s_tdata[32*i +: 32];
		end
	end

	// stage 2: squares
	logic             v_s2;
	pair_t            pair_s2;
	logic [2:0][63:0] sq_s2;

	// stage 3: sum and cutoff
	logic             v_s3;
	pair_t            pair_s3;
	logic [63:0]      rsq_s3;
	logic [63:0]      rsq_w;

	assign rsq_w = sq_s2[0] + sq_s2[1] + sq_s2[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pair_s1 <= pair_in;
			pair_s2 <= pair_s1;
			for (int i = 0; i < 3; i++) begin
				sq_s2[i] <= pair_s1.mag[i] * pair_s1.mag[i];
			end
			pair_s3.mag    <= pair_s2.mag;
			pair_s3.neg    <= pair_s2.neg;
			pair_s3.in_cut <= rsq_w < {16'h0, cutoff_q, 16'h0};
			rsq_s3         <= rsq_w;
		end
	end

	// square root
	logic        rt_v;
	logic [31:0] rt_r;
	logic [PAIR_W-1:0] rt_sb;

	plpf_sqrt #(.SBW(PAIR_W)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_v     (v_s3),
		.in_rad   (rsq_s3),
		.in_sb    (pair_s3),
		.out_v    (rt_v),
		.out_root (rt_r),
		.out_sb   (rt_sb)
	);

	// stage 4: base test
	logic v_s4;
	geo_t geo_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= rt_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			geo_s4.pair    <= pair_t'(rt_sb);
			geo_s4.r       <= rt_r;
			geo_s4.base_ok <= rt_r < sigma_q;
		end
	end

	// r / sigma
	logic             qd_v;
	logic [15:0]      qd_q;
	logic [GEO_W-1:0] qd_sb;

	plpf_div #(.NB(16), .SBW(GEO_W)) u_div_ratio (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_v     (v_s4),
		.in_rem   (geo_s4.base_ok ? geo_s4.r : 32'd0),
		.in_low   (16'h0),
		.divisor  (sigma_q),
		.in_sb    (geo_s4),
		.out_v    (qd_v),
		.out_quot (qd_q),
		.out_sb   (qd_sb)
	);

	// stage 5: base
	logic        v_s5;
	logic [16:0] b_s5;
	geo_t        geo_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= qd_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			b_s5   <= 17'h1_0000 - {1'b0, qd_q};
			geo_s5 <= geo_t'(qd_sb);
		end
	end

	// -log2(b)
	logic             lg_v;
	logic [20:0]      lg_nl;
	logic [GEO_W-1:0] lg_sb;

	plpf_log2 #(.SBW(GEO_W)) u_log2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_v     (v_s5),
		.in_base  (b_s5),
		.in_sb    (geo_s5),
		.out_v    (lg_v),
		.out_nlog (lg_nl),
		.out_sb   (lg_sb)
	);

	// b^(alpha-1) and b^alpha
	logic             pa_v;
	logic [31:0]      pa_pw;
	logic [GEO_W-1:0] pa_sb;
	logic [31:0]      pb_pw;

	plpf_pow #(.SBW(GEO_W)) u_pow_force (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.in_v    (lg_v),
		.in_nlog (lg_nl),
		.expo    (alpha_m1_q),
		.in_sb   (lg_sb),
		.out_v   (pa_v),
		.out_pow (pa_pw),
		.out_sb  (pa_sb)
	);

	plpf_pow #(.SBW(1)) u_pow_energy (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.in_v    (lg_v),
		.in_nlog (lg_nl),
		.expo    (alpha_q),
		.in_sb   (1'b0),
		.out_v   (),
		.out_pow (pb_pw),
		.out_sb  ()
	);

	// stage 6: numerators
	logic        v_s6;
	logic [48:0] nf_s6;
	logic [48:0] ne_s6;
	geo_t        geo_s6;

	// stage 7: saturation check and divider setup
	logic        v_s7;
	fdiv_t       fd_s7;
	logic        sate_s7;
	logic [31:0] remf_s7;
	logic [31:0] lowf_s7;
	logic [31:0] reme_s7;
	logic [31:0] lowe_s7;
	logic        satf_w;
	logic        sate_w;

	assign satf_w = {15'h0, nf_s6[48:32]} >= sigma_q;
	assign sate_w = {15'h0, ne_s6[48:32]} >= alpha_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s6 <= pa_v;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nf_s6      <= eps_q * pa_pw[16:0];
			ne_s6      <= eps_q * pb_pw[16:0];
			geo_s6     <= geo_t'(pa_sb);
			fd_s7.geo  <= geo_s6;
			fd_s7.sat  <= satf_w;
			sate_s7    <= sate_w;
			remf_s7    <= satf_w ? 32'd0 : {15'h0, nf_s6[48:32]};
			lowf_s7    <= nf_s6[31:0];
			reme_s7    <= sate_w ? 32'd0 : {15'h0, ne_s6[48:32]};
			lowe_s7    <= ne_s6[31:0];
		end
	end

	// eps*P1/sigma and eps*P/alpha
	logic              fq_v;
	logic [31:0]       fq_q;
	logic [FDIV_W-1:0] fq_sb;
	logic [31:0]       eq_q;
	logic              eq_sat;

	plpf_div #(.NB(32), .SBW(FDIV_W)) u_div_force (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_v     (v_s7),
		.in_rem   (remf_s7),
		.in_low   (lowf_s7),
		.divisor  (sigma_q),
		.in_sb    (fd_s7),
		.out_v    (fq_v),
		.out_quot (fq_q),
		.out_sb   (fq_sb)
	);

	plpf_div #(.NB(32), .SBW(1)) u_div_energy (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_v     (v_s7),
		.in_rem   (reme_s7),
		.in_low   (lowe_s7),
		.divisor  (alpha_q),
		.in_sb    (sate_s7),
		.out_v    (),
		.out_quot (eq_q),
		.out_sb   (eq_sat)
	);

	// stage 8: force magnitude and energy
	logic        v_s8;
	logic [31:0] fmag_s8;
	logic [31:0] en_s8;
	geo_t        geo_s8;
	fdiv_t       fq_w;

	assign fq_w = fdiv_t'(fq_sb);

	// stage 9: scale divider setup
	logic        v_s9;
	sdiv_t       sd_s9;
	logic [31:0] rems_s9;
	logic [31:0] lows_s9;
	logic [31:0] r_s9;
	logic        sats_w;

	assign sats_w = {16'h0, fmag_s8[31:16]} >= geo_s8.r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (adv) begin
			v_s8 <= fq_v;
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fmag_s8       <= fq_w.sat ? SAT32 : fq_q;
			en_s8         <= eq_sat ? SAT32 : eq_q;
			geo_s8        <= fq_w.geo;
			sd_s9.pair    <= geo_s8.pair;
			sd_s9.live    <= geo_s8.pair.in_cut & geo_s8.base_ok;
			sd_s9.r_nz    <= geo_s8.r != '0;
			sd_s9.energy  <= en_s8;
			sd_s9.sat     <= sats_w;
			rems_s9       <= sats_w ? 32'd0 : {16'h0, fmag_s8[31:16]};
			lows_s9       <= {fmag_s8[15:0], 16'h0};
			r_s9          <= geo_s8.r;
		end
	end

	// (F << 16) / r
	logic              sq_v;
	logic [31:0]       sq_q;
	logic [SDIV_W-1:0] sq_sb;
	sdiv_t             sq_w;

	plpf_div #(.NB(32), .SBW(SDIV_W)) u_div_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_v     (v_s9),
		.in_rem   (rems_s9),
		.in_low   (lows_s9),
		.divisor  (r_s9),
		.in_sb    (sd_s9),
		.out_v    (sq_v),
		.out_quot (sq_q),
		.out_sb   (sq_sb)
	);

	assign sq_w = sdiv_t'(sq_sb);

	// stage 10: masking
	logic        v_s10;
	pair_t       pair_s10;
	logic [31:0] scale_s10;
	logic [31:0] en_s10;

	// stage 11: component products
	logic             v_s11;
	pair_t            pair_s11;
	logic [31:0]      scale_s11;
	logic [31:0]      en_s11;
	logic [2:0][63:0] prod_s11;

	// stage 12: output register
	logic             v_s12;
	logic [2:0][31:0] push_s12;
	logic [31:0]      scale_s12;
	logic [31:0]      en_s12;
	logic             within_s12;
	logic [2:0][31:0] push_w;

	always_comb begin
		logic [47:0] qv;
		for (int i = 0; i < 3; i++) begin
			qv = prod_s11[i][63:16];
			if (pair_s11.neg[i]) begin
				push_w[i] = (qv > 48'h8000_0000) ? 32'h8000_0000 : 32'(-qv);
			end else begin
				push_w[i] = (qv > 48'h7FFF_FFFF) ? 32'h7FFF_FFFF : qv[31:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
		end else if (adv) begin
			v_s10 <= sq_v;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pair_s10  <= sq_w.pair;
			scale_s10 <= !(sq_w.live && sq_w.r_nz) ? 32'd0 : (sq_w.sat ? SAT32 : sq_q);
			en_s10    <= (sq_w.live && energy_en_q) ? sq_w.energy : 32'd0;
			pair_s11  <= pair_s10;
			scale_s11 <= scale_s10;
			en_s11    <= en_s10;
			for (int i = 0; i < 3; i++) begin
				prod_s11[i] <= pair_s10.mag[i] * scale_s10;
			end
			push_s12   <= push_w;
			scale_s12  <= scale_s11;
			en_s12     <= en_s11;
			within_s12 <= pair_s11.in_cut;
		end
	end

	assign adv      = !v_s12 || m_tready;
	assign s_tready = adv;
	assign m_tvalid = v_s12;
	assign m_tdata  = {en_s12, scale_s12, push_s12[2], push_s12[1], push_s12[0]};
	assign m_tuser  = within_s12;

endmodule

FILE: src/plpf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plpf_checker
// Port-level checks of the power-law pair force block, bound to its top.
// ----------------------------------------------------------------------------
module plpf_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [159:0] m_tdata,
	input logic         m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output transaction changed while stalled");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input accepted while output stalled");

	a_out_of_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("out-of-range pair with nonzero result");

	a_zero_scale_zero_push: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[127:96] == 32'd0 |-> m_tdata[95:0] == '0)
		else $error("force components without force scale");

endmodule

bind power_law_pair_force plpf_checker u_checker (.*);
